### design/ssg_pkg.sv
// Shared types and constants of the sine sample generator.
// No dependencies; every other file of the block imports it.
package ssg_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int INDEX_BITS    = 16;
  localparam int REG_BITS      = 16;
  localparam int PHASE_BITS    = 16;
  localparam int DIV_STAGES    = INDEX_BITS + 1;
  localparam int CORDIC_STAGES = 24;
  localparam int QBITS         = 30;
  localparam int CW            = 34;   // CORDIC x/y width
  localparam int ZW            = 33;   // CORDIC angle width

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;

  // atan(2^-i) in Q30 radians, truncated
  localparam logic [31:0] ATAN_ROM [CORDIC_STAGES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [1:0] {
    REG_PERIOD     = 2'd0,
    REG_LEVEL_LOW  = 2'd1,
    REG_LEVEL_HIGH = 2'd2,
    REG_NONE       = 2'd3
  } cfg_reg_e;

  // what travels beside the data in every pipeline stage
  typedef struct packed {
    logic valid;
    logic cfg_bad;
    logic idx_bad;
  } side_t;

endpackage

### design/ssg_phase_div.sv
// Pipelined restoring divider: phase = (index * 2^16 + period/2) / period, mod 2^16.
// One quotient bit per stage. Depends on ssg_pkg.
module ssg_phase_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ssg_pkg::side_t                  side_i,
  input  logic [ssg_pkg::INDEX_BITS-1:0]  index_i,
  input  logic [ssg_pkg::REG_BITS-1:0]    period_i,
  output ssg_pkg::side_t                  side_o,
  output logic [ssg_pkg::PHASE_BITS-1:0]  phase_o
);
  import ssg_pkg::*;

  logic [15:0] rem_q [DIV_STAGES];
  logic [16:0] num_q [DIV_STAGES];
  logic [15:0] quo_q [DIV_STAGES];
  side_t       side_q [DIV_STAGES];

  logic [15:0] rem_in [DIV_STAGES];
  logic [16:0] num_in [DIV_STAGES];
  logic [15:0] quo_in [DIV_STAGES];
  logic [15:0] rem_d [DIV_STAGES];
  logic [16:0] num_d [DIV_STAGES];
  logic [15:0] quo_d [DIV_STAGES];

  always_comb begin
    logic [16:0] t;
    logic        ge;
    t  = '0;
    ge = 1'b0;
    // the dividend's low half is period/2, so no adder is needed
    rem_in[0] = {1'b0, index_i[15:1]};
    num_in[0] = {index_i[0], 1'b0, period_i[15:1]};
    quo_in[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_in[k] = rem_q[k-1];
      num_in[k] = num_q[k-1];
      quo_in[k] = quo_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      t  = {rem_in[k], num_in[k][16]};
      ge = (t >= {1'b0, period_i});
      rem_d[k] = ge ? 16'(t - {1'b0, period_i}) : t[15:0];
      num_d[k] = {num_in[k][15:0], 1'b0};
      quo_d[k] = {quo_in[k][14:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < DIV_STAGES; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= num_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign side_o  = side_q[DIV_STAGES-1];
  assign phase_o = quo_q[DIV_STAGES-1];

endmodule

### design/ssg_cordic.sv
// Pipelined rotation CORDIC: quarter-turn phase to Q30 angle, then one
// micro-rotation per stage. Depends on ssg_pkg.
module ssg_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ssg_pkg::side_t                  side_i,
  input  logic [ssg_pkg::PHASE_BITS-1:0]  phase_i,
  output ssg_pkg::side_t                  side_o,
  output logic [1:0]                      quad_o,
  output logic signed [ssg_pkg::CW-1:0]   cos_o,
  output logic signed [ssg_pkg::CW-1:0]   sin_o
);
  import ssg_pkg::*;

  logic signed [ZW-1:0] z0_q;
  logic [1:0]           quad0_q;
  side_t                side0_q;

  logic signed [CW-1:0] cx_q [CORDIC_STAGES];
  logic signed [CW-1:0] cy_q [CORDIC_STAGES];
  logic signed [ZW-1:0] cz_q [CORDIC_STAGES];
  logic [1:0]           quad_q [CORDIC_STAGES];
  side_t                side_q [CORDIC_STAGES];

  logic signed [CW-1:0] cx_in [CORDIC_STAGES];
  logic signed [CW-1:0] cy_in [CORDIC_STAGES];
  logic signed [ZW-1:0] cz_in [CORDIC_STAGES];
  logic signed [CW-1:0] cx_d [CORDIC_STAGES];
  logic signed [CW-1:0] cy_d [CORDIC_STAGES];
  logic signed [ZW-1:0] cz_d [CORDIC_STAGES];

  logic [44:0]          z_prod;
  logic signed [ZW-1:0] z0_d;

  // angle = round(r * (pi/2) / 2^14) in Q30
  assign z_prod = 45'(phase_i[13:0]) * 45'(HALF_PI_Q30);
  assign z0_d   = ZW'((z_prod + 45'd8192) >> 14);

  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;
    dx = '0;
    dy = '0;
    at = '0;
    cx_in[0] = CW'(GAIN_Q30);
    cy_in[0] = '0;
    cz_in[0] = z0_q;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      cx_in[i] = cx_q[i-1];
      cy_in[i] = cy_q[i-1];
      cz_in[i] = cz_q[i-1];
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = cy_in[i] >>> i;
      dy = cx_in[i] >>> i;
      at = ZW'(ATAN_ROM[i]);
      if (!cz_in[i][ZW-1]) begin
        cx_d[i] = cx_in[i] - dx;
        cy_d[i] = cy_in[i] + dy;
        cz_d[i] = cz_in[i] - at;
      end else begin
        cx_d[i] = cx_in[i] + dx;
        cy_d[i] = cy_in[i] - dy;
        cz_d[i] = cz_in[i] + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
      for (int i = 0; i < CORDIC_STAGES; i++) side_q[i] <= '0;
    end else if (en_i) begin
      side0_q   <= side_i;
      side_q[0] <= side0_q;
      for (int i = 1; i < CORDIC_STAGES; i++) side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q      <= z0_d;
      quad0_q   <= phase_i[15:14];
      quad_q[0] <= quad0_q;
      for (int i = 1; i < CORDIC_STAGES; i++) quad_q[i] <= quad_q[i-1];
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        cz_q[i] <= cz_d[i];
      end
    end
  end

  assign side_o = side_q[CORDIC_STAGES-1];
  assign quad_o = quad_q[CORDIC_STAGES-1];
  assign cos_o  = cx_q[CORDIC_STAGES-1];
  assign sin_o  = cy_q[CORDIC_STAGES-1];

endmodule

### design/sine_sample_generator_core.sv
// Top level of the sine sample generator: configuration registers, entry
// stage, phase divider, CORDIC and the scaling stages. Depends on ssg_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | sample_index_i
//   out     | output    | out_valid_o / out_stall_i| sample_value_o, config_error_o,
//           |           |                          | index_error_o
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One item per clock while the output is not held. Stages: 1 entry, 17
// divider, 1 angle, 24 CORDIC, then select, multiply, add, clamp/output register.
// All stages advance together; a held output with out_stall_i high freezes the
// whole pipeline, and in_stall_o follows it in the same cycle.
// Reset clears the valid bits and loads period 256, levels 1 and 65535.
module sine_sample_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [ssg_pkg::REG_BITS-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ssg_pkg::INDEX_BITS-1:0]   sample_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ssg_pkg::SAMPLE_BITS-1:0]  sample_value_o,
  output logic                             config_error_o,
  output logic                             index_error_o
);
  import ssg_pkg::*;

  logic [15:0] period_q, level_low_q, level_high_q;
  logic        en;
  logic [16:0] lvl_sum;
  logic [15:0] mid, pp;
  logic        cfg_bad, idx_bad;

  side_t       side0_q;
  logic [15:0] index0_q;
  side_t       div_side, cor_side;
  logic [15:0] phase;
  logic [1:0]  quad;
  logic signed [CW-1:0] cos_v, sin_v;

  side_t                 sel_side_q, mul_side_q, add_side_q;
  logic signed [31:0]    s_q;
  logic signed [48:0]    prod_q;
  logic signed [18:0]    v_q;
  logic signed [CW-1:0]  s_d;
  logic signed [48:0]    rnd;
  logic signed [48:0]    shf;
  logic [15:0]           sample_d;

  logic [15:0] sample_q;
  logic        cfg_err_q, idx_err_q, out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= 16'd256;
      level_low_q  <= 16'd1;
      level_high_q <= 16'd65535;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PERIOD:     period_q     <= cfg_data_i;
        REG_LEVEL_LOW:  level_low_q  <= cfg_data_i;
        REG_LEVEL_HIGH: level_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the user must keep the levels static while items are in flight; the block itself does not enforce it
  assign lvl_sum = {1'b0, level_low_q} + {1'b0, level_high_q};
  assign mid     = lvl_sum[16:1];
  assign pp      = mid - level_low_q;
  assign cfg_bad = (period_q <= 16'd10) || (level_high_q <= level_low_q) ||
                   (level_low_q == '0);
  assign idx_bad = (sample_index_i >= period_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q    <= '0;
      sel_side_q <= '0;
      mul_side_q <= '0;
      add_side_q <= '0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      side0_q    <= '{valid: in_valid_i, cfg_bad: cfg_bad, idx_bad: idx_bad};
      sel_side_q <= cor_side;
      mul_side_q <= sel_side_q;
      add_side_q <= mul_side_q;
      out_vld_q  <= add_side_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) index0_q <= sample_index_i;
  end

  ssg_phase_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .side_i  (side0_q),
    .index_i (index0_q),
    .period_i(period_q),
    .side_o  (div_side),
    .phase_o (phase)
  );

  ssg_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (div_side),
    .phase_i(phase),
    .side_o (cor_side),
    .quad_o (quad),
    .cos_o  (cos_v),
    .sin_o  (sin_v)
  );

  // unfold the quadrant
  always_comb begin
    case (quad)
      2'd0:    s_d = sin_v;
      2'd1:    s_d = cos_v;
      2'd2:    s_d = -sin_v;
      default: s_d = -cos_v;
    endcase
  end

  assign rnd = prod_q + (49'sd1 <<< (QBITS - 1));
  assign shf = rnd >>> QBITS;

  always_comb begin
    if (add_side_q.cfg_bad) begin
      sample_d = '0;
    end else if (add_side_q.idx_bad) begin
      sample_d = mid;
    end else if (v_q < $signed({3'b000, level_low_q})) begin
      sample_d = level_low_q;
    end else if (v_q > $signed({3'b000, level_high_q})) begin
      sample_d = level_high_q;
    end else begin
      sample_d = v_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q       <= s_d[31:0];
      prod_q    <= $signed({1'b0, pp}) * s_q;
      v_q       <= $signed({3'b000, mid}) + shf[18:0];
      sample_q  <= sample_d;
      cfg_err_q <= add_side_q.cfg_bad;
      idx_err_q <= add_side_q.idx_bad;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sample_value_o = sample_q;
  assign config_error_o = cfg_err_q;
  assign index_error_o  = idx_err_q;

endmodule

### design/ssg_checker.sv
// Port-level checks of the sine sample generator, bound to the top level.
// Depends on ssg_pkg and sine_sample_generator_core.
module ssg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [ssg_pkg::SAMPLE_BITS-1:0]  sample_value_o,
  input logic                             config_error_o,
  input logic                             index_error_o
);
  import ssg_pkg::*;

  // input side only stalls while a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held item");

  // a bad configuration forces the sample to zero
  a_cfg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && config_error_o) |-> (sample_value_o == '0))
    else $error("sample not zero under configuration error");

  // a held item keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_value_o) &&
      $stable(config_error_o) && $stable(index_error_o)))
    else $error("held item changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight after reset");

endmodule

bind sine_sample_generator_core ssg_checker u_ssg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sample_value_o(sample_value_o),
  .config_error_o(config_error_o),
  .index_error_o (index_error_o)
);

### tb/sv/sine_sample_generator_core_test.sv
// Self-checking testbench for sine_sample_generator_core: a queue-fed driver,
// a stalling receiver and a monitor against a CORDIC sine predictor.
// Depends on ssg_pkg and the core RTL.
`timescale 1ns / 100ps

module sine_sample_generator_core_test;
  import ssg_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic                   cfg_err;
    logic                   idx_err;
  } sample_res_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [1:0]             cfg_idx_i = REG_NONE;
  logic [REG_BITS-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [INDEX_BITS-1:0]  sample_index_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_value_o;
  logic                   config_error_o;
  logic                   index_error_o;

  logic [INDEX_BITS-1:0]  period_q = 16'd256;
  logic [SAMPLE_BITS-1:0] lvl_low_q = 16'd1;
  logic [SAMPLE_BITS-1:0] lvl_high_q = 16'd65535;

  logic [INDEX_BITS-1:0]  index_queue[$];
  sample_res_t            sample_queue[$];
  int                     errors = 0;
  int                     cycles = 0;
  bit                     in_taken = 1'b0;
  bit                     send_hold = 1'b0;
  bit                     long_hold_req = 1'b0;
  int                     burst_left = 0;
  int                     gap_left = 0;
  int                     hold_left = 0;

  sine_sample_generator_core DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic sample_res_t sine_sample(logic [INDEX_BITS-1:0] idx);
    sample_res_t res;
    longint n, lo, hi, mid, pp, ph, quad, r, cx, cy, cz, dx, dy, s, v;
    n   = period_q;
    lo  = lvl_low_q;
    hi  = lvl_high_q;
    mid = (lo + hi) >> 1;
    pp  = mid - lo;
    res.cfg_err = (n <= 10) || (hi <= lo) || (lo == 0);
    res.idx_err = (longint'(idx) >= n);
    if (res.cfg_err) begin
      res.value = '0;
    end else if (res.idx_err) begin
      res.value = mid[SAMPLE_BITS-1:0];
    end else begin
      ph   = (((longint'(idx) << PHASE_BITS) + (n >> 1)) / n) & 64'hFFFF;
      quad = ph >> (PHASE_BITS - 2);
      r    = ph & ((64'd1 << (PHASE_BITS - 2)) - 1);
      cz   = (r * longint'(HALF_PI_Q30) + (64'd1 << (PHASE_BITS - 3))) >> (PHASE_BITS - 2);
      cx   = longint'(GAIN_Q30);
      cy   = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cz >= 0) begin
          cx -= dx; cy += dy; cz -= longint'(ATAN_ROM[i]);
        end else begin
          cx += dx; cy -= dy; cz += longint'(ATAN_ROM[i]);
        end
      end
      case (quad)
        0: s = cy;
        1: s = cx;
        2: s = -cy;
        default: s = -cx;
      endcase
      v = mid + ((pp * s + (longint'(1) << (QBITS - 1))) >>> QBITS);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      res.value = v[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    sample_res_t exp_res;
    cycles <= cycles + 1;
    in_taken = in_valid_i && !in_stall_o;
    if (in_taken) sample_queue.push_back(sine_sample(sample_index_i));
    if (out_valid_o && !out_stall_i) begin
      if (sample_queue.size() == 0) begin
        $error("unexpected sample: value %0d", sample_value_o);
        errors++;
      end else begin
        exp_res = sample_queue.pop_front();
        if (sample_value_o !== exp_res.value) begin
          $error("sample_value: expected %0d, got %0d", exp_res.value, sample_value_o);
          errors++;
        end
        if (config_error_o !== exp_res.cfg_err) begin
          $error("config_error: expected %0b, got %0b", exp_res.cfg_err, config_error_o);
          errors++;
        end
        if (index_error_o !== exp_res.idx_err) begin
          $error("index_error: expected %0b, got %0b", exp_res.idx_err, index_error_o);
          errors++;
        end
      end
    end
    if (cycles > TIMEOUT_CYCLES) begin
      $display("** sine_sample_generator_core: FAILED **");
      $finish;
    end
  end

  // driver: bursts of items with random gaps; hold a stalled item
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (send_hold || index_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        sample_index_i <= index_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: steps through no stall, two random stall densities and a periodic stall; a long hold overrides them
  always @(negedge clk_i) begin
    if (long_hold_req && hold_left == 0) hold_left <= 300;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case ((cycles / 400) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ((cycles % 16) < 3);
      endcase
    end
  end

  task automatic wait_idle();
    while (index_queue.size() != 0 || in_valid_i || sample_queue.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [REG_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PERIOD:     period_q = data;
      REG_LEVEL_LOW:  lvl_low_q = data;
      REG_LEVEL_HIGH: lvl_high_q = data;
      default: ;
    endcase
  endtask

  task automatic set_levels(int n, int lo, int hi);
    write_reg(REG_PERIOD, n[15:0]);
    write_reg(REG_LEVEL_LOW, lo[15:0]);
    write_reg(REG_LEVEL_HIGH, hi[15:0]);
  endtask

  // edge indices of the period plus random items, mostly in range
  task automatic queue_items(int count);
    int n;
    n = period_q;
    index_queue.push_back(16'd0);
    index_queue.push_back(16'hFFFF);
    if (n > 0) begin
      index_queue.push_back(16'(n - 1));
      index_queue.push_back(16'(n));
      index_queue.push_back(16'(n / 4));
      index_queue.push_back(16'(n / 2));
      index_queue.push_back(16'(3 * n / 4));
    end
    for (int i = 0; i < count; i++) begin
      if (n > 0 && $urandom_range(0, 9) < 8)
        index_queue.push_back(16'($urandom_range(0, n - 1)));
      else
        index_queue.push_back(16'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, with a long receiver hold while items keep coming
    queue_items(20);
    wait_idle();
    queue_items(150);
    long_hold_req = 1'b1;
    repeat (10) @(posedge clk_i);
    long_hold_req = 1'b0;
    repeat (40) @(posedge clk_i);
    send_hold = 1'b1;
    while (sample_queue.size() != 0) @(posedge clk_i);
    send_hold = 1'b0;
    wait_idle();

    set_levels(11, 1, 65535);     queue_items(80);  wait_idle();
    set_levels(65535, 1, 65535);  queue_items(80);  wait_idle();
    set_levels(1000, 100, 200);   queue_items(80);  wait_idle();
    set_levels(10, 1, 100);       queue_items(40);  wait_idle();
    set_levels(500, 0, 100);      queue_items(40);  wait_idle();
    set_levels(500, 300, 300);    queue_items(40);  wait_idle();
    set_levels(0, 5, 6);          queue_items(30);  wait_idle();
    set_levels(777, 65534, 65535); queue_items(60); wait_idle();
    write_reg(REG_NONE, 16'h0005); queue_items(30); wait_idle();
    set_levels(65535, 65535, 0);  queue_items(30);  wait_idle();
    for (int k = 0; k < 5; k++) begin
      set_levels($urandom_range(11, 65535), $urandom_range(1, 30000),
                 $urandom_range(30001, 65535));
      queue_items(80);
      wait_idle();
    end

    if (errors == 0) begin
      $display("** sine_sample_generator_core: PASSED **");
    end else begin
      $display("** sine_sample_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
